// ----- design/cld_pkg.sv -----
// Shared types and codes for the circular list deque core.
// No dependencies; imported by every module of the block but cld_ram.
package cld_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 7;

  // operation codes of a request
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;
  localparam logic [2:0] OP_DUMP      = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
  } out_item_t;

endpackage

// ----- design/cld_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/cld_front.sv -----
// Request intake: accepts requests, drops unused op codes and buffers
// the rest in a two-entry queue for the back end. Depends on cld_pkg.
module cld_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cld_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output cld_pkg::in_item_t cmd,
  input  logic              cmd_pop
);
  import cld_pkg::*;

  in_item_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       op_used;
  logic       push;
  logic       pop;

  // only the six defined ops enter the queue
  always_comb begin
    unique case (in_item.op) inside
      OP_INS_FRONT, OP_INS_BACK, OP_REM_FRONT, OP_REM_BACK, OP_SEARCH, OP_DUMP:
        op_used = 1'b1;
      default:
        op_used = 1'b0;
    endcase
  end

  assign busy      = (fill_r == 2'd2);
  assign push      = start && !busy && op_used;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ----- design/cld_back.sv -----
// Execution back end: ring pointers, entry RAM and the walk sequencer for
// search and dump. Depends on cld_pkg and cld_ram.
module cld_back #(
  parameter int DEPTH = cld_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cld_pkg::in_item_t  cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  output cld_pkg::out_item_t out_item
);
  import cld_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                      state_r, state_nxt;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          off_r, off_nxt;
  logic                      dump_r, dump_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]          rd_off_r, rd_off_nxt;
  logic                      out_vld_r, out_vld_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [IDX_W-1:0]          ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic [IDX_W-1:0]          front_dec;
  logic [IDX_W-1:0]          front_inc;
  logic [IDX_W-1:0]          tail_slot;
  logic                      issue;
  logic                      is_last;
  logic                      done;

  // ring slot of a list offset below DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign tail_slot = slot_of(front_r, cnt_r);
  assign ram_raddr = slot_of(front_r, off_r);
  assign is_last   = (rd_off_r == cnt_r - CNT_W'(1));

  cld_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    cnt_nxt      = cnt_r;
    off_nxt      = off_r;
    dump_nxt     = dump_r;
    key_nxt      = key_r;
    rd_vld_nxt   = 1'b0;
    rd_off_nxt   = off_r;
    out_vld_nxt  = 1'b0;
    out_item_nxt = '{status: ST_OK, position: '0, data: '0, last: 1'b1};
    ram_we       = 1'b0;
    ram_waddr    = tail_slot;
    cmd_pop      = 1'b0;
    issue        = 1'b0;
    done         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op) inside
            OP_INS_FRONT, OP_INS_BACK: begin
              out_vld_nxt = 1'b1;
              if (cnt_r == CNT_FULL) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                if (cmd.op == OP_INS_FRONT) begin
                  ram_waddr = front_dec;
                  front_nxt = front_dec;
                end
              end
            end
            OP_REM_FRONT, OP_REM_BACK: begin
              out_vld_nxt = 1'b1;
              if (cnt_r == '0) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
                if (cmd.op == OP_REM_FRONT) begin
                  front_nxt = front_inc;
                end
              end
            end
            OP_SEARCH, OP_DUMP: begin
              if (cnt_r == '0) begin
                out_vld_nxt         = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
                off_nxt   = '0;
                dump_nxt  = (cmd.op == OP_DUMP);
                key_nxt   = cmd.value;
              end
            end
            default: begin
              out_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        // judge the entry read last cycle
        if (rd_vld_r) begin
          if (dump_r) begin
            out_vld_nxt       = 1'b1;
            out_item_nxt.data = ram_rdata;
            out_item_nxt.last = is_last;
            done              = is_last;
          end else if (ram_rdata == key_r) begin
            out_vld_nxt           = 1'b1;
            out_item_nxt.position = POS_W'(rd_off_r) + POS_W'(1);
            done                  = 1'b1;
          end else if (is_last) begin
            out_vld_nxt         = 1'b1;
            out_item_nxt.status = ST_NOT_FOUND;
            done                = 1'b1;
          end
        end
        // issue the next read
        issue = (off_r < cnt_r) && !done;
        if (issue) begin
          rd_vld_nxt = 1'b1;
          off_nxt    = off_r + CNT_W'(1);
        end
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      cnt_r     <= '0;
      off_r     <= '0;
      dump_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      cnt_r     <= cnt_nxt;
      off_r     <= off_nxt;
      dump_r    <= dump_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    rd_off_r   <= rd_off_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/circular_list_deque_core.sv -----
// Top level of the circular list deque core: a deque of signed values
// with search and dump. Depends on cld_pkg, cld_front, cld_back, cld_ram.
//
// A request is taken on a rising edge with start high and busy low. Each
// result appears on out_item for exactly one cycle with out_valid high;
// the receiver cannot stall, so capture every strobe. Inserts and
// removals give one registered result each, and the back end takes one
// of them per cycle while no walk is in progress. Search and dump walk
// the entry RAM one entry per cycle through its single registered read
// port: a dump of N entries streams N results, a search gives one
// result. Removals, searches and dumps on an empty list answer with
// status empty and no walk. A two-entry request queue sits between
// intake and execution, and busy rises only when it is full. Op codes
// 6 and 7 are accepted and dropped with no result. After reset the
// block is ready at once; no clearing pass is made.
module circular_list_deque_core #(
  parameter int DEPTH = cld_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cld_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cld_pkg::out_item_t out_item
);
  import cld_pkg::*;

  // request handed from the queue to the back end
  logic     cmd_valid;
  in_item_t cmd;
  logic     cmd_pop;

  // accept, drop unused ops, buffer
  cld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // execute against the ring and drive the result strobe
  cld_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
